### design/svm_pkg.sv
// Shared types and constants for the stereo voice mixer.
`timescale 1ns / 1ps
package svm_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VOL_L,
    S_MUL_L,
    S_VOL_R,
    S_MUL_R,
    S_ACC_R,
    S_EMIT
  } svm_state_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2  = 2'd3;

  localparam logic [7:0]  MASTER_VOL_RST = 8'd255;
  localparam logic [4:0]  RING_LOG2_RST  = 5'd14;
  localparam logic [4:0]  RING_LOG2_MIN  = 5'd4;
  localparam logic [4:0]  RING_LOG2_MAX  = 5'd16;

  localparam logic [15:0] SAT_MAX  = 16'h7fff;
  localparam logic [15:0] SAT_MIN  = 16'h8000;
  localparam logic [7:0]  OFFSET8  = 8'h80;

  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

endpackage

### design/stereo_voice_mixer_with_output_convert_unit.sv
// Top level of the stereo voice mixer with output conversion.
//
// Input channel (in_*): one beat per mixer item, valid/ready. The block
// takes one item at a time; in_ready is high only while it waits for work.
// An item with a voice runs through S_VOL_L, S_MUL_L, S_VOL_R, S_MUL_R
// and S_ACC_R, using the single shared 17x17 multiplier four times per
// voice (two volume products, two sample products), plus accumulate steps.
// An item marked last then passes through S_EMIT to load the output register.
// Output channel (out_*): one beat per frame, registered. A stalled result
// holds; the next items of a new frame are still taken, and only a further
// last item waits until the pending beat has gone.
// Configuration (cfg_*): write-only, one register per cycle. The user must
// apply writes only while no item is in flight; the block does not enforce it.
// Reset (rst_n low, synchronous): registers return to defaults, the
// accumulators and frame position clear, and the output beat is dropped.
`timescale 1ns / 1ps
module stereo_voice_mixer_with_output_convert_unit
  import svm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_first_of_frame,
  input  logic                 in_raw_valid,
  input  logic signed [23:0]   in_raw_left,
  input  logic signed [23:0]   in_raw_right,
  input  logic                 in_voice_valid,
  input  logic signed [15:0]   in_voice_sample,
  input  logic [7:0]           in_voice_left_vol,
  input  logic [7:0]           in_voice_right_vol,
  input  logic                 in_last_of_frame,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_ring_index,
  output logic [15:0]          out_left_word,
  output logic [15:0]          out_right_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  svm_state_t state_r, state_nxt;

  logic [7:0]  master_vol_r;
  logic        eight_bit_r;
  logic        stereo_r;
  logic [4:0]  ring_log2_r;

  logic [31:0] acc_l_r, acc_r_r;
  logic [15:0] fpos_r;
  logic signed [15:0] smp_r;
  logic [7:0]  lvol_r, rvol_r;
  logic        last_r;

  logic        out_valid_r;
  logic [15:0] ring_index_r, left_word_r, right_word_r;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [31:0]              contrib;
  logic                     add_l, add_r, emit_go, take;

  logic [15:0] conv_l, conv_r;
  logic [4:0]  ring_n;
  logic [15:0] ring_mask, ring_pos;

  assign take    = in_valid && in_ready;
  assign emit_go = !out_valid_r || out_ready;
  assign contrib = {{(32 - (PROD_W - 8)){prod[PROD_W-1]}}, prod[PROD_W-1:8]};

  svm_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  svm_conv u_conv_l (.acc(acc_l_r[31:8]), .eight_bit(eight_bit_r), .word(conv_l));
  svm_conv u_conv_r (.acc(acc_r_r[31:8]), .eight_bit(eight_bit_r), .word(conv_r));

  always_comb begin
    priority if (ring_log2_r < RING_LOG2_MIN) begin
      ring_n = RING_LOG2_MIN;
    end else if (ring_log2_r > RING_LOG2_MAX) begin
      ring_n = RING_LOG2_MAX;
    end else begin
      ring_n = ring_log2_r;
    end
  end

  assign ring_mask = 16'((17'd1 << ring_n) - 17'd1);
  assign ring_pos  = stereo_r ? {fpos_r[14:0], 1'b0} : fpos_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (in_voice_valid) begin
            state_nxt = S_VOL_L;
          end else if (in_last_of_frame) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_VOL_L: state_nxt = S_MUL_L;
      S_MUL_L: state_nxt = S_VOL_R;
      S_VOL_R: state_nxt = S_MUL_R;
      S_MUL_R: state_nxt = S_ACC_R;
      S_ACC_R: state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    add_l    = 1'b0;
    add_r    = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_VOL_L: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(signed'({1'b0, lvol_r}));
        mul_b  = MUL_W'(signed'({1'b0, master_vol_r}));
      end
      S_MUL_L, S_MUL_R: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(smp_r);
        mul_b  = signed'({1'b0, prod[15:0]});
      end
      S_VOL_R: begin
        add_l  = 1'b1;
        mul_en = 1'b1;
        mul_a  = MUL_W'(signed'({1'b0, rvol_r}));
        mul_b  = MUL_W'(signed'({1'b0, master_vol_r}));
      end
      S_ACC_R: add_r = 1'b1;
      S_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      master_vol_r <= MASTER_VOL_RST;
      eight_bit_r  <= 1'b0;
      stereo_r     <= 1'b1;
      ring_log2_r  <= RING_LOG2_RST;
      acc_l_r      <= '0;
      acc_r_r      <= '0;
      fpos_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MASTER_VOL: master_vol_r <= cfg_wdata;
          CFG_EIGHT_BIT:  eight_bit_r  <= cfg_wdata[0];
          CFG_STEREO:     stereo_r     <= cfg_wdata[0];
          CFG_RING_LOG2:  ring_log2_r  <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (take && in_first_of_frame) begin
        acc_l_r <= in_raw_valid ? 32'(in_raw_left)  : '0;
        acc_r_r <= in_raw_valid ? 32'(in_raw_right) : '0;
      end
      if (add_l) begin
        acc_l_r <= acc_l_r + contrib;
      end
      if (add_r) begin
        acc_r_r <= acc_r_r + contrib;
      end
      if (state_r == S_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
        fpos_r      <= fpos_r + 16'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      smp_r  <= in_voice_sample;
      lvol_r <= in_voice_left_vol;
      rvol_r <= in_voice_right_vol;
      last_r <= in_last_of_frame;
    end
    if (state_r == S_EMIT && emit_go) begin
      ring_index_r <= ring_pos & ring_mask;
      left_word_r  <= conv_l;
      right_word_r <= stereo_r ? conv_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ring_index = ring_index_r;
  assign out_left_word  = left_word_r;
  assign out_right_word = right_word_r;

  a_voice_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_voice_valid |=> state_r == S_VOL_L)
    else $error("voice beat did not start the multiply sequence");

  a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && emit_go |=> out_valid_r && fpos_r == $past(fpos_r) + 16'd1)
    else $error("emit did not load output and advance frame position");

  a_eight_bit_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && eight_bit_r |-> out_left_word[15:8] == 8'd0
      && out_right_word[15:8] == 8'd0)
    else $error("eight-bit output has upper byte set");

  a_mono_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !stereo_r |-> out_right_word == 16'd0)
    else $error("mono output has nonzero right word");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> !$past(take))
    else $error("item taken while sequencer busy");

endmodule

### design/svm_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module svm_mul
  import svm_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### design/svm_conv.sv
// Accumulator to output word: shift, saturate and format.
`timescale 1ns / 1ps
module svm_conv
  import svm_pkg::*;
(
  input  logic [23:0] acc,
  input  logic        eight_bit,
  output logic [15:0] word
);

  logic [23:0] v;
  logic [15:0] sat;

  // acc carries the accumulator already shifted right by 8
  assign v = acc;

  always_comb begin
    if (!v[23] && (|v[22:15])) begin
      sat = SAT_MAX;
    end else if (v[23] && !(&v[22:15])) begin
      sat = SAT_MIN;
    end else begin
      sat = v[15:0];
    end
  end

  assign word = eight_bit ? {8'd0, sat[15:8] ^ OFFSET8} : sat;

endmodule
